/* rtl/coap_pkg.sv */
package coap_pkg;

    localparam int unsigned DATA_W     = 8;
    localparam int unsigned TKL_W      = 4;
    localparam int unsigned OPT_LEN_W  = 17;
    localparam int unsigned OPT_CNT_W  = 8;
    localparam int unsigned PAY_LEN_W  = 16;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned TYPE_W     = 2;
    localparam int unsigned MID_W      = 16;
    localparam int unsigned OPT_NUM_W  = 16;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;

    localparam logic [TKL_W-1:0]     MAX_TKL_RST       = 4'd8;
    localparam logic [OPT_LEN_W-1:0] MAX_OPT_LEN_RST   = 17'd1034;
    localparam logic [OPT_CNT_W-1:0] MAX_OPT_CNT_RST   = 8'd16;
    localparam logic [PAY_LEN_W-1:0] MAX_PAY_LEN_RST   = 16'd1024;

    localparam logic [1:0] REG_MAX_TKL     = 2'd0;
    localparam logic [1:0] REG_MAX_OPT_LEN = 2'd1;
    localparam logic [1:0] REG_MAX_OPT_CNT = 2'd2;
    localparam logic [1:0] REG_MAX_PAY_LEN = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NONE      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TOKEN     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OPT_START = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OPT_BYTE  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HEADER    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OPTION    = 2'd3;

    localparam logic [1:0]        PROTO_VER      = 2'd1;
    localparam logic [TKL_W-1:0]  TKL_LIMIT      = 4'd8;
    localparam logic [3:0]        NIB_EXT8       = 4'd13;
    localparam logic [3:0]        NIB_EXT16      = 4'd14;
    localparam logic [3:0]        NIB_RESERVED   = 4'd15;
    localparam logic [7:0]        PAYLOAD_MARKER = 8'hFF;
    localparam logic [OPT_LEN_W-1:0] EXT8_OFFSET  = 17'd13;
    localparam logic [OPT_LEN_W-1:0] EXT16_OFFSET = 17'd269;
    localparam logic [OPT_NUM_W:0]   OPT_NUM_MAX  = 17'h0FFFF;

    typedef enum logic [3:0] {
        PH_H0,
        PH_H1,
        PH_H2,
        PH_H3,
        PH_TOKEN,
        PH_OPT,
        PH_DEXT1,
        PH_DEXT2,
        PH_LEXT1,
        PH_LEXT2,
        PH_VALUE,
        PH_PAYLOAD,
        PH_ERROR
    } phase_t;

endpackage

/* rtl/coap_message_stream_decoder_core.sv */
// channel   | direction | ports                               | accepted when
// ----------+-----------+-------------------------------------+------------------------
// request   | in        | s_valid/s_ready, s_data_byte, ...   | s_valid && s_ready
// result    | out       | m_valid/m_ready, m_item_kind, ...   | m_valid && m_ready
// config    | in        | psel/penable/pwrite/paddr/pwdata    | psel && penable && pwrite
//
// one request per cycle while s_ready is high, result valid in the cycle after acceptance (single output register)
// parse state and result register updated together at the accepting edge
// s_ready is high whenever the output register is empty or being drained
// aresetn is synchronous, active low; clears parse state and loads register defaults
module coap_message_stream_decoder_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [coap_pkg::DATA_W-1:0]         s_data_byte,
    input  logic                                s_last_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [coap_pkg::KIND_W-1:0]         m_item_kind,
    output logic [coap_pkg::TYPE_W-1:0]         m_msg_type,
    output logic [coap_pkg::TKL_W-1:0]          m_tok_len,
    output logic [coap_pkg::DATA_W-1:0]         m_msg_code,
    output logic [coap_pkg::MID_W-1:0]          m_msg_id,
    output logic [coap_pkg::OPT_NUM_W-1:0]      m_opt_num,
    output logic [coap_pkg::OPT_LEN_W-1:0]      m_option_length,
    output logic [coap_pkg::DATA_W-1:0]         m_value_byte,
    output logic [coap_pkg::STATUS_W-1:0]       m_status,
    output logic                                m_done_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [coap_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [coap_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [coap_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import coap_pkg::*;

    logic [TKL_W-1:0]     max_tkl_reg;
    logic [OPT_LEN_W-1:0] max_opt_len_reg;
    logic [OPT_CNT_W-1:0] max_opt_cnt_reg;
    logic [PAY_LEN_W-1:0] max_pay_len_reg;

    phase_t               phase_reg, phase_next;
    logic [OPT_LEN_W-1:0] byte_count_reg, byte_count_next;
    logic [23:0]          header_reg, header_next;
    logic [OPT_NUM_W-1:0] last_num_reg, last_num_next;
    logic [3:0]           dnib_reg, dnib_next;
    logic [3:0]           lnib_reg, lnib_next;
    logic [7:0]           ext_reg, ext_next;
    logic [OPT_LEN_W-1:0] delta_reg, delta_next;
    logic [OPT_LEN_W-1:0] remain_reg, remain_next;
    logic [OPT_CNT_W-1:0] tally_reg, tally_next;
    logic [STATUS_W-1:0]  err_reg, err_next;

    logic                 m_valid_reg;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [TYPE_W-1:0]    type_reg, type_next;
    logic [TKL_W-1:0]     tkl_reg, tkl_next;
    logic [DATA_W-1:0]    code_reg, code_next;
    logic [MID_W-1:0]     mid_reg, mid_next;
    logic [OPT_NUM_W-1:0] onum_reg, onum_next;
    logic [OPT_LEN_W-1:0] olen_reg, olen_next;
    logic [DATA_W-1:0]    vbyte_reg, vbyte_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 done_reg, done_next;

    logic                 in_acc;
    logic                 cfg_wr;

    logic [7:0]           b0;
    logic [TKL_W-1:0]     tkl;
    logic                 do_len;
    logic [3:0]           len_nib;
    logic                 do_fin;
    logic [OPT_LEN_W-1:0] fin_len;
    logic [OPT_NUM_W+1:0] fin_num;

    assign in_acc  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_MAX_TKL:     prdata = {{(APB_DATA_W-TKL_W){1'b0}}, max_tkl_reg};
            REG_MAX_OPT_LEN: prdata = {{(APB_DATA_W-OPT_LEN_W){1'b0}}, max_opt_len_reg};
            REG_MAX_OPT_CNT: prdata = {{(APB_DATA_W-OPT_CNT_W){1'b0}}, max_opt_cnt_reg};
            REG_MAX_PAY_LEN: prdata = {{(APB_DATA_W-PAY_LEN_W){1'b0}}, max_pay_len_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_tkl_reg     <= MAX_TKL_RST;
            max_opt_len_reg <= MAX_OPT_LEN_RST;
            max_opt_cnt_reg <= MAX_OPT_CNT_RST;
            max_pay_len_reg <= MAX_PAY_LEN_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MAX_TKL:     max_tkl_reg     <= pwdata[TKL_W-1:0];
                REG_MAX_OPT_LEN: max_opt_len_reg <= pwdata[OPT_LEN_W-1:0];
                REG_MAX_OPT_CNT: max_opt_cnt_reg <= pwdata[OPT_CNT_W-1:0];
                REG_MAX_PAY_LEN: max_pay_len_reg <= pwdata[PAY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        header_next     = header_reg;
        last_num_next   = last_num_reg;
        dnib_next       = dnib_reg;
        lnib_next       = lnib_reg;
        ext_next        = ext_reg;
        delta_next      = delta_reg;
        remain_next     = remain_reg;
        tally_next      = tally_reg;
        err_next        = err_reg;

        kind_next   = KIND_NONE;
        type_next   = '0;
        tkl_next    = '0;
        code_next   = '0;
        mid_next    = '0;
        onum_next   = '0;
        olen_next   = '0;
        vbyte_next  = '0;
        status_next = ST_OK;
        done_next   = 1'b0;

        b0      = header_reg[23:16];
        tkl     = b0[3:0];
        do_len  = 1'b0;
        len_nib = lnib_reg;
        do_fin  = 1'b0;
        fin_len = '0;

        case (phase_reg)
            PH_H0: begin
                header_next = {s_data_byte, 16'h0000};
                phase_next  = PH_H1;
            end
            PH_H1: begin
                header_next = {header_reg[23:16], s_data_byte, 8'h00};
                phase_next  = PH_H2;
            end
            PH_H2: begin
                header_next = {header_reg[23:8], s_data_byte};
                phase_next  = PH_H3;
            end
            PH_H3: begin
                if (b0[7:6] != PROTO_VER || tkl > TKL_LIMIT || tkl > max_tkl_reg) begin
                    err_next   = ST_HEADER;
                    phase_next = PH_ERROR;
                end else begin
                    kind_next   = KIND_HEADER;
                    type_next   = b0[5:4];
                    tkl_next    = tkl;
                    code_next   = header_reg[15:8];
                    mid_next    = {header_reg[7:0], s_data_byte};
                    remain_next = {{(OPT_LEN_W-TKL_W){1'b0}}, tkl};
                    phase_next  = (tkl != '0) ? PH_TOKEN : PH_OPT;
                end
            end
            PH_TOKEN, PH_VALUE: begin
                kind_next   = (phase_reg == PH_TOKEN) ? KIND_TOKEN : KIND_OPT_BYTE;
                vbyte_next  = s_data_byte;
                remain_next = remain_reg - 1'b1;
                if (remain_next == '0) begin
                    phase_next = PH_OPT;
                end
            end
            PH_OPT: begin
                if (s_data_byte == PAYLOAD_MARKER) begin
                    byte_count_next = '0;
                    phase_next      = PH_PAYLOAD;
                end else begin
                    dnib_next = s_data_byte[7:4];
                    lnib_next = s_data_byte[3:0];
                    if (s_data_byte[7:4] == NIB_RESERVED || s_data_byte[3:0] == NIB_RESERVED) begin
                        err_next   = ST_MALFORMED;
                        phase_next = PH_ERROR;
                    end else if (s_data_byte[7:4] == NIB_EXT8 ||
                                 s_data_byte[7:4] == NIB_EXT16) begin
                        phase_next = PH_DEXT1;
                    end else begin
                        delta_next = {{(OPT_LEN_W-4){1'b0}}, s_data_byte[7:4]};
                        do_len     = 1'b1;
                        len_nib    = s_data_byte[3:0];
                    end
                end
            end
            PH_DEXT1: begin
                if (dnib_reg == NIB_EXT8) begin
                    delta_next = EXT8_OFFSET + {{(OPT_LEN_W-8){1'b0}}, s_data_byte};
                    do_len     = 1'b1;
                end else begin
                    ext_next   = s_data_byte;
                    phase_next = PH_DEXT2;
                end
            end
            PH_DEXT2: begin
                delta_next = EXT16_OFFSET + {1'b0, ext_reg, s_data_byte};
                do_len     = 1'b1;
            end
            PH_LEXT1: begin
                if (lnib_reg == NIB_EXT8) begin
                    do_fin  = 1'b1;
                    fin_len = EXT8_OFFSET + {{(OPT_LEN_W-8){1'b0}}, s_data_byte};
                end else begin
                    ext_next   = s_data_byte;
                    phase_next = PH_LEXT2;
                end
            end
            PH_LEXT2: begin
                do_fin  = 1'b1;
                fin_len = EXT16_OFFSET + {1'b0, ext_reg, s_data_byte};
            end
            PH_PAYLOAD: begin
                byte_count_next = byte_count_reg + 1'b1;
                if (byte_count_next > {1'b0, max_pay_len_reg}) begin
                    err_next   = ST_MALFORMED;
                    phase_next = PH_ERROR;
                end else begin
                    kind_next  = KIND_PAYLOAD;
                    vbyte_next = s_data_byte;
                end
            end
            default: begin
                phase_next = PH_ERROR;
            end
        endcase

        if (do_len) begin
            if (len_nib == NIB_EXT8 || len_nib == NIB_EXT16) begin
                phase_next = PH_LEXT1;
            end else begin
                do_fin  = 1'b1;
                fin_len = {{(OPT_LEN_W-4){1'b0}}, len_nib};
            end
        end

        fin_num = {2'b00, last_num_reg} + {1'b0, delta_next};

        if (do_fin) begin
            if (fin_len > max_opt_len_reg || fin_num > OPT_NUM_MAX ||
                tally_reg >= max_opt_cnt_reg) begin
                err_next   = ST_OPTION;
                phase_next = PH_ERROR;
            end else begin
                tally_next    = tally_reg + 1'b1;
                last_num_next = fin_num[OPT_NUM_W-1:0];
                kind_next     = KIND_OPT_START;
                onum_next     = fin_num[OPT_NUM_W-1:0];
                olen_next     = fin_len;
                if (fin_len != '0) begin
                    remain_next = fin_len;
                    phase_next  = PH_VALUE;
                end else begin
                    phase_next = PH_OPT;
                end
            end
        end

        if (s_last_byte) begin
            done_next = 1'b1;
            if (phase_next == PH_ERROR) begin
                status_next = err_next;
            end else if (phase_next == PH_OPT ||
                         (phase_next == PH_PAYLOAD && byte_count_next != '0)) begin
                status_next = ST_OK;
            end else begin
                status_next = ST_MALFORMED;
            end
            phase_next      = PH_H0;
            byte_count_next = '0;
            header_next     = '0;
            last_num_next   = '0;
            dnib_next       = '0;
            lnib_next       = '0;
            ext_next        = '0;
            delta_next      = '0;
            remain_next     = '0;
            tally_next      = '0;
            err_next        = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_H0;
            byte_count_reg <= '0;
            header_reg     <= '0;
            last_num_reg   <= '0;
            dnib_reg       <= '0;
            lnib_reg       <= '0;
            ext_reg        <= '0;
            delta_reg      <= '0;
            remain_reg     <= '0;
            tally_reg      <= '0;
            err_reg        <= ST_OK;
        end else if (in_acc) begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            header_reg     <= header_next;
            last_num_reg   <= last_num_next;
            dnib_reg       <= dnib_next;
            lnib_reg       <= lnib_next;
            ext_reg        <= ext_next;
            delta_reg      <= delta_next;
            remain_reg     <= remain_next;
            tally_reg      <= tally_next;
            err_reg        <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            kind_reg   <= kind_next;
            type_reg   <= type_next;
            tkl_reg    <= tkl_next;
            code_reg   <= code_next;
            mid_reg    <= mid_next;
            onum_reg   <= onum_next;
            olen_reg   <= olen_next;
            vbyte_reg  <= vbyte_next;
            status_reg <= status_next;
            done_reg   <= done_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_item_kind     = kind_reg;
    assign m_msg_type      = type_reg;
    assign m_tok_len       = tkl_reg;
    assign m_msg_code      = code_reg;
    assign m_msg_id        = mid_reg;
    assign m_opt_num       = onum_reg;
    assign m_option_length = olen_reg;
    assign m_value_byte    = vbyte_reg;
    assign m_status        = status_reg;
    assign m_done_res      = done_reg;

endmodule

/* tb/sv/coap_decode_checker.sv */
module coap_decode_checker
    import coap_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [DATA_W-1:0]       s_data_byte,
    input  logic                    s_last_byte,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [KIND_W-1:0]       m_item_kind,
    input  logic [TYPE_W-1:0]       m_msg_type,
    input  logic [TKL_W-1:0]        m_tok_len,
    input  logic [DATA_W-1:0]       m_msg_code,
    input  logic [MID_W-1:0]        m_msg_id,
    input  logic [OPT_NUM_W-1:0]    m_opt_num,
    input  logic [OPT_LEN_W-1:0]    m_option_length,
    input  logic [DATA_W-1:0]       m_value_byte,
    input  logic [STATUS_W-1:0]     m_status,
    input  logic                    m_done_res,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    input  logic                    pready,
    output int                      mismatches,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [TYPE_W-1:0]      mtype;
        logic [TKL_W-1:0]       tkl;
        logic [DATA_W-1:0]      code;
        logic [MID_W-1:0]       mid;
        logic [OPT_NUM_W-1:0]   onum;
        logic [OPT_LEN_W-1:0]   olen;
        logic [DATA_W-1:0]      vbyte;
        logic [STATUS_W-1:0]    status;
        logic                   done;
    } decoded_item_t;

    // limits as last written over the register port
    logic [TKL_W-1:0]       lim_tkl;
    logic [OPT_LEN_W-1:0]   lim_olen;
    logic [OPT_CNT_W-1:0]   lim_ocnt;
    logic [PAY_LEN_W-1:0]   lim_pay;

    // parser state
    phase_t                 stage;
    logic [23:0]            hdr_bytes;
    logic [OPT_NUM_W-1:0]   prev_num;
    logic [3:0]             delta_nib;
    logic [3:0]             len_nib;
    logic [7:0]             ext_high;
    logic [OPT_LEN_W-1:0]   opt_delta;
    logic [OPT_LEN_W-1:0]   bytes_left;
    logic [OPT_CNT_W-1:0]   opts_seen;
    logic [OPT_LEN_W-1:0]   pay_seen;
    logic [STATUS_W-1:0]    first_err;

    decoded_item_t          outcome;
    decoded_item_t          predicted_items[$];
    int                     fail_count = 0;

    function automatic void restart_parse();
        stage      = PH_H0;
        hdr_bytes  = '0;
        prev_num   = '0;
        delta_nib  = '0;
        len_nib    = '0;
        ext_high   = '0;
        opt_delta  = '0;
        bytes_left = '0;
        opts_seen  = '0;
        pay_seen   = '0;
        first_err  = '0;
    endfunction

    function automatic void abort_message(input logic [STATUS_W-1:0] code);
        first_err = code;
        stage     = PH_ERROR;
    endfunction

    function automatic void close_option(input int unsigned len);
        int unsigned num;
        num = prev_num + opt_delta;
        if (len > lim_olen || num > OPT_NUM_MAX || opts_seen >= lim_ocnt) begin
            abort_message(ST_OPTION);
        end else begin
            opts_seen    = opts_seen + 1'b1;
            prev_num     = num[OPT_NUM_W-1:0];
            outcome.kind = KIND_OPT_START;
            outcome.onum = num[OPT_NUM_W-1:0];
            outcome.olen = len[OPT_LEN_W-1:0];
            if (len > 0) begin
                bytes_left = len[OPT_LEN_W-1:0];
                stage      = PH_VALUE;
            end else begin
                stage = PH_OPT;
            end
        end
    endfunction

    function automatic void after_delta();
        if (len_nib == NIB_EXT8 || len_nib == NIB_EXT16) begin
            stage = PH_LEXT1;
        end else begin
            close_option(len_nib);
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        logic [7:0] b0;
        outcome = '0;
        b0 = hdr_bytes[23:16];
        case (stage)
            PH_H0: begin
                hdr_bytes = {b, 16'h0000};
                stage = PH_H1;
            end
            PH_H1: begin
                hdr_bytes = {hdr_bytes[23:16], b, 8'h00};
                stage = PH_H2;
            end
            PH_H2: begin
                hdr_bytes[7:0] = b;
                stage = PH_H3;
            end
            PH_H3: begin
                if (b0[7:6] != PROTO_VER || b0[3:0] > TKL_LIMIT || b0[3:0] > lim_tkl) begin
                    abort_message(ST_HEADER);
                end else begin
                    outcome.kind  = KIND_HEADER;
                    outcome.mtype = b0[5:4];
                    outcome.tkl   = b0[3:0];
                    outcome.code  = hdr_bytes[15:8];
                    outcome.mid   = {hdr_bytes[7:0], b};
                    bytes_left    = b0[3:0];
                    stage = (b0[3:0] != 0) ? PH_TOKEN : PH_OPT;
                end
            end
            PH_TOKEN: begin
                outcome.kind  = KIND_TOKEN;
                outcome.vbyte = b;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0) stage = PH_OPT;
            end
            PH_OPT: begin
                if (b == PAYLOAD_MARKER) begin
                    pay_seen = '0;
                    stage = PH_PAYLOAD;
                end else begin
                    delta_nib = b[7:4];
                    len_nib   = b[3:0];
                    if (delta_nib == NIB_RESERVED || len_nib == NIB_RESERVED) begin
                        abort_message(ST_MALFORMED);
                    end else if (delta_nib == NIB_EXT8 || delta_nib == NIB_EXT16) begin
                        stage = PH_DEXT1;
                    end else begin
                        opt_delta = delta_nib;
                        after_delta();
                    end
                end
            end
            PH_DEXT1: begin
                if (delta_nib == NIB_EXT8) begin
                    opt_delta = EXT8_OFFSET + b;
                    after_delta();
                end else begin
                    ext_high = b;
                    stage = PH_DEXT2;
                end
            end
            PH_DEXT2: begin
                opt_delta = EXT16_OFFSET + {ext_high, b};
                after_delta();
            end
            PH_LEXT1: begin
                if (len_nib == NIB_EXT8) begin
                    close_option(EXT8_OFFSET + b);
                end else begin
                    ext_high = b;
                    stage = PH_LEXT2;
                end
            end
            PH_LEXT2: begin
                close_option(EXT16_OFFSET + {ext_high, b});
            end
            PH_VALUE: begin
                outcome.kind  = KIND_OPT_BYTE;
                outcome.vbyte = b;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0) stage = PH_OPT;
            end
            PH_PAYLOAD: begin
                pay_seen = pay_seen + 1'b1;
                if (pay_seen > lim_pay) begin
                    abort_message(ST_MALFORMED);
                end else begin
                    outcome.kind  = KIND_PAYLOAD;
                    outcome.vbyte = b;
                end
            end
            default: begin
                stage = PH_ERROR;
            end
        endcase
        if (last) begin
            if (stage == PH_ERROR) begin
                outcome.status = first_err;
            end else if (stage == PH_OPT || (stage == PH_PAYLOAD && pay_seen > 0)) begin
                outcome.status = ST_OK;
            end else begin
                outcome.status = ST_MALFORMED;
            end
            outcome.done = 1'b1;
            restart_parse();
        end
    endfunction

    function automatic string describe(input decoded_item_t r);
        return $sformatf({"kind=%0d type=%0d tkl=%0d code=%0h mid=%0h num=%0d len=%0d",
                          " byte=%0h status=%0d done=%0d"},
                         r.kind, r.mtype, r.tkl, r.code, r.mid, r.onum, r.olen,
                         r.vbyte, r.status, r.done);
    endfunction

    always @(posedge aclk) begin
        decoded_item_t exp_item;
        decoded_item_t act_item;
        string bad;
        if (!aresetn) begin
            restart_parse();
            lim_tkl  = MAX_TKL_RST;
            lim_olen = MAX_OPT_LEN_RST;
            lim_ocnt = MAX_OPT_CNT_RST;
            lim_pay  = MAX_PAY_LEN_RST;
            predicted_items.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MAX_TKL:     lim_tkl  = pwdata[TKL_W-1:0];
                    REG_MAX_OPT_LEN: lim_olen = pwdata[OPT_LEN_W-1:0];
                    REG_MAX_OPT_CNT: lim_ocnt = pwdata[OPT_CNT_W-1:0];
                    REG_MAX_PAY_LEN: lim_pay  = pwdata[PAY_LEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                decode_byte(s_data_byte, s_last_byte);
                predicted_items.push_back(outcome);
            end
            if (m_valid && m_ready) begin
                act_item = {m_item_kind, m_msg_type, m_tok_len, m_msg_code, m_msg_id,
                            m_opt_num, m_option_length, m_value_byte, m_status,
                            m_done_res};
                if (predicted_items.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result with no request waiting: %s", $time,
                                 describe(act_item));
                    end
                end else begin
                    exp_item = predicted_items.pop_front();
                    bad = "";
                    if (act_item.kind !== exp_item.kind)     bad = {bad, " item_kind"};
                    if (act_item.mtype !== exp_item.mtype)   bad = {bad, " msg_type"};
                    if (act_item.tkl !== exp_item.tkl)       bad = {bad, " tok_len"};
                    if (act_item.code !== exp_item.code)     bad = {bad, " msg_code"};
                    if (act_item.mid !== exp_item.mid)       bad = {bad, " msg_id"};
                    if (act_item.onum !== exp_item.onum)     bad = {bad, " opt_num"};
                    if (act_item.olen !== exp_item.olen)     bad = {bad, " option_length"};
                    if (act_item.vbyte !== exp_item.vbyte)   bad = {bad, " value_byte"};
                    if (act_item.status !== exp_item.status) bad = {bad, " status"};
                    if (act_item.done !== exp_item.done)     bad = {bad, " done_res"};
                    if (bad != "") begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch in%s", $time, bad);
                            $display("  expected %s", describe(exp_item));
                            $display("  actual   %s", describe(act_item));
                        end
                    end
                end
            end
        end
        mismatches <= fail_count;
        pending    <= predicted_items.size();
    end

endmodule

/* tb/sv/coap_message_stream_decoder_core_tb.sv */
module coap_message_stream_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import coap_pkg::*;

    localparam int CYCLE_LIMIT       = 1000000;
    localparam int ITEMS_PER_SETTING = 165;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [DATA_W-1:0]      s_data_byte;
    logic                   s_last_byte;
    logic                   m_valid;
    logic                   m_ready;
    logic [KIND_W-1:0]      m_item_kind;
    logic [TYPE_W-1:0]      m_msg_type;
    logic [TKL_W-1:0]       m_tok_len;
    logic [DATA_W-1:0]      m_msg_code;
    logic [MID_W-1:0]       m_msg_id;
    logic [OPT_NUM_W-1:0]   m_opt_num;
    logic [OPT_LEN_W-1:0]   m_option_length;
    logic [DATA_W-1:0]      m_value_byte;
    logic [STATUS_W-1:0]    m_status;
    logic                   m_done_res;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int                     mismatches;
    int                     pending;
    int unsigned            cycles = 0;
    int unsigned            sent = 0;
    logic [7:0]             msg[$];
    bit                     burst;

    coap_message_stream_decoder_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_msg_type      (m_msg_type),
        .m_tok_len       (m_tok_len),
        .m_msg_code      (m_msg_code),
        .m_msg_id        (m_msg_id),
        .m_opt_num       (m_opt_num),
        .m_option_length (m_option_length),
        .m_value_byte    (m_value_byte),
        .m_status        (m_status),
        .m_done_res      (m_done_res),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    coap_decode_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_msg_type      (m_msg_type),
        .m_tok_len       (m_tok_len),
        .m_msg_code      (m_msg_code),
        .m_msg_id        (m_msg_id),
        .m_opt_num       (m_opt_num),
        .m_option_length (m_option_length),
        .m_value_byte    (m_value_byte),
        .m_status        (m_status),
        .m_done_res      (m_done_res),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side stalls, with quiet stretches where it never stalls
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if ((cycles % 512) < 128 || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                stall = pick_gap();
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    function automatic logic [3:0] nib_of(input int unsigned v);
        if (v >= EXT16_OFFSET) return NIB_EXT16;
        if (v >= EXT8_OFFSET) return NIB_EXT8;
        return v[3:0];
    endfunction

    function automatic void push_ext(input int unsigned v);
        int unsigned x;
        if (v >= EXT16_OFFSET) begin
            x = v - EXT16_OFFSET;
            msg.push_back(x[15:8]);
            msg.push_back(x[7:0]);
        end else if (v >= EXT8_OFFSET) begin
            x = v - EXT8_OFFSET;
            msg.push_back(x[7:0]);
        end
    endfunction

    // mostly well-formed messages, some truncated or corrupted, some noise
    function automatic void build_message();
        int unsigned ver, tkl, nopt, d, l, n, r, pos;
        msg.delete();
        r = $urandom_range(0, 99);
        if (r < 10) begin
            n = $urandom_range(1, 10);
            repeat (n) msg.push_back(8'($urandom));
        end else begin
            ver = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 3) : PROTO_VER;
            tkl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 8);
            msg.push_back({ver[1:0], 2'($urandom), tkl[3:0]});
            repeat (3) msg.push_back(8'($urandom));
            repeat (tkl) msg.push_back(8'($urandom));
            nopt = $urandom_range(0, 4);
            repeat (nopt) begin
                r = $urandom_range(0, 19);
                d = (r < 14) ? $urandom_range(0, 12) :
                    (r < 18) ? $urandom_range(13, 268) : $urandom_range(269, 65804);
                r = $urandom_range(0, 59);
                l = (r < 50) ? $urandom_range(0, 12) :
                    (r < 59) ? $urandom_range(13, 40) : $urandom_range(269, 275);
                msg.push_back({nib_of(d), nib_of(l)});
                push_ext(d);
                push_ext(l);
                repeat (l) msg.push_back(8'($urandom));
            end
            r = $urandom_range(0, 24);
            if (r == 0) begin
                msg.push_back(PAYLOAD_MARKER);
            end else if (r < 17) begin
                msg.push_back(PAYLOAD_MARKER);
                n = $urandom_range(1, 20);
                repeat (n) msg.push_back(8'($urandom));
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                n = $urandom_range(1, msg.size());
                while (msg.size() > n) void'(msg.pop_back());
            end else if (r == 1 && msg.size() > 4) begin
                pos = $urandom_range(4, msg.size() - 1);
                msg[pos] = ($urandom_range(0, 1) == 1) ? 8'($urandom)
                                                      : {4'($urandom), NIB_RESERVED};
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_message();
        burst = ($urandom_range(0, 3) == 0);
        foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
        sent += msg.size();
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned goal;
        goal = sent + target;
        while (sent < goal) begin
            build_message();
            send_message();
        end
    endtask

    // hold off requests until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_limits(input int unsigned tkl, input int unsigned olen,
                                input int unsigned ocnt, input int unsigned pay);
        drain();
        write_reg(REG_MAX_TKL, tkl);
        write_reg(REG_MAX_OPT_LEN, olen);
        write_reg(REG_MAX_OPT_CNT, ocnt);
        write_reg(REG_MAX_PAY_LEN, pay);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        s_last_byte = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        burst       = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bad version with token length at the limit
        msg = '{8'hC8, 8'hFF, 8'h00, 8'hFF};
        send_message();
        // message ends inside the header
        msg = '{8'h40, 8'h01};
        send_message();
        // token, two-byte delta extension, value byte, option header as final byte
        msg = '{8'h51, 8'h45, 8'h12, 8'h34, 8'hA5, 8'hE0, 8'h00, 8'h01, 8'h01, 8'h3C, 8'h00};
        send_message();
        // marker with no payload
        msg = '{8'h40, 8'h00, 8'h00, 8'h00, PAYLOAD_MARKER};
        send_message();
        // reserved length nibble
        msg = '{8'h40, 8'h00, 8'h00, 8'h00, 8'h1F};
        send_message();

        run_random(ITEMS_PER_SETTING);
        apply_limits(15, 65804, 255, 65535);
        run_random(ITEMS_PER_SETTING);
        apply_limits(0, 0, 0, 0);
        run_random(ITEMS_PER_SETTING);
        apply_limits(4, 20, 3, 10);
        run_random(ITEMS_PER_SETTING);
        apply_limits($urandom_range(0, 8), $urandom_range(0, 300),
                     $urandom_range(0, 8), $urandom_range(0, 40));
        run_random(ITEMS_PER_SETTING);
        apply_limits(MAX_TKL_RST, MAX_OPT_LEN_RST, MAX_OPT_CNT_RST, MAX_PAY_LEN_RST);
        run_random(ITEMS_PER_SETTING);

        drain();
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
